// ===== design/mplr_pkg.sv =====
// Shared widths, codes and types of the midpoint line rasterizer.
`default_nettype none

package mplr_pkg;

    // Width of one centred coordinate.
    localparam int COORD_BITS  = 11;
    // A difference of two coordinates needs one more bit.
    localparam int DELTA_BITS  = COORD_BITS + 1;
    // The decision value ranges over about four times the major length.
    localparam int DEC_BITS    = COORD_BITS + 4;
    localparam int SCREEN_BITS = 12;
    localparam int REG_BITS    = 12;
    localparam int COLOUR_BITS = 4;
    localparam int SUM_BITS    = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

    localparam int S_TDATA_RAW  = 4 * COORD_BITS + COLOUR_BITS;
    localparam int S_TDATA_BITS = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TDATA_RAW  = 2 * SCREEN_BITS + COLOUR_BITS;
    localparam int M_TDATA_BITS = ((M_TDATA_RAW + 7) / 8) * 8;

    localparam int REG_INDEX_BITS = 1;
    localparam logic [REG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [REG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [REG_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd640;
    localparam logic [REG_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd480;

    typedef enum logic {
        MODE_START   = 1'b0,
        MODE_ADVANCE = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        OCT_ONE   = 3'd0,
        OCT_TWO   = 3'd1,
        OCT_THREE = 3'd2,
        OCT_FOUR  = 3'd3,
        OCT_FIVE  = 3'd4,
        OCT_SIX   = 3'd5,
        OCT_SEVEN = 3'd6,
        OCT_EIGHT = 3'd7
    } octant_t;

    typedef logic signed [COORD_BITS-1:0]  coord_t;
    typedef logic signed [DELTA_BITS-1:0]  delta_t;
    typedef logic signed [DEC_BITS-1:0]    decision_t;
    typedef logic signed [SCREEN_BITS-1:0] screen_t;
    typedef logic [COLOUR_BITS-1:0]        colour_t;

    typedef struct packed {
        coord_t  start_x;
        coord_t  start_y;
        coord_t  end_x;
        coord_t  end_y;
        colour_t colour;
    } line_cmd_t;

    typedef struct packed {
        logic      active;
        octant_t   octant;
        coord_t    cur_x;
        coord_t    cur_y;
        coord_t    stop_x;
        coord_t    stop_y;
        delta_t    delta_x;
        delta_t    delta_y;
        decision_t decision;
        colour_t   line_colour;
    } line_state_t;

    typedef struct packed {
        screen_t screen_x;
        screen_t screen_y;
        colour_t pixel_colour;
        logic    last;
    } pixel_t;

endpackage

`default_nettype wire

// ===== design/midpoint_line_rasterizer_unit.sv =====
// Top level of the eight-octant midpoint line rasterizer.
//
//  Channel  Direction  Signals                          Carries
//  s_       in         s_tvalid s_tready s_tdata s_tuser line command (start or advance)
//  m_       out        m_tvalid m_tready m_tdata m_tlast one screen pixel
//  cfg_     in         cfg_we cfg_index cfg_wdata       screen width and height
//
// Each accepted command passes through one short step of adds and compares fed by the
// line state registers, and any pixel it yields is registered in the main or skid register.
// A two-entry output (main register plus skid register) lets a command be taken
// while a pixel still waits; s_tready drops only while the skid register is full.
// aresetn is synchronous and active low; it idles the line and empties the output.
// The screen size registers reset to 640 by 480.
`default_nettype none

module midpoint_line_rasterizer_unit (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    // s_tdata, lowest bit first: start_x, start_y, end_x, end_y, colour, zero fill
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    input  wire [mplr_pkg::S_TDATA_BITS-1:0]        s_tdata,
    // s_tuser: mode (0 start a line, 1 advance one pixel)
    input  wire                                     s_tuser,
    // m_tdata, lowest bit first: screen_x, screen_y, pixel_colour, zero fill
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    output logic [mplr_pkg::M_TDATA_BITS-1:0]       m_tdata,
    output logic                                    m_tlast,
    input  wire                                     cfg_we,
    input  wire [mplr_pkg::REG_INDEX_BITS-1:0]      cfg_index,
    input  wire [mplr_pkg::REG_BITS-1:0]            cfg_wdata
);
    import mplr_pkg::*;

    logic [REG_BITS-1:0] width_reg, height_reg;

    line_state_t state_reg, state_next;
    line_cmd_t   cmd;
    pixel_t      step_pixel;
    logic        step_has_result;

    pixel_t out_reg, out_next;
    pixel_t skid_reg, skid_next;
    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;

    logic   accept;
    logic   produce;

    // The input payload packs the four endpoints and the colour from bit zero upward.
    assign cmd = '{
        start_x: s_tdata[COORD_BITS-1:0],
        start_y: s_tdata[2*COORD_BITS-1:COORD_BITS],
        end_x:   s_tdata[3*COORD_BITS-1:2*COORD_BITS],
        end_y:   s_tdata[4*COORD_BITS-1:3*COORD_BITS],
        colour:  s_tdata[4*COORD_BITS+COLOUR_BITS-1:4*COORD_BITS]
    };

    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign produce  = accept & step_has_result;

    mplr_step u_step (
        .mode          (s_tuser),
        .cmd           (cmd),
        .state         (state_reg),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .state_next    (state_next),
        .has_result    (step_has_result),
        .pixel         (step_pixel)
    );

    // Configuration writes; an index with no register behind it is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SCREEN_WIDTH_RESET;
            height_reg <= SCREEN_HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                REG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                default: begin
                    width_reg <= width_reg;
                end
            endcase
        end
    end

    // Line state: all fields clear on reset, which leaves the block idle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Output register with skid: a new pixel goes to the main register when it is
    // free or being emptied in this cycle, and is parked in the skid register otherwise.
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (produce) begin
            if (!out_valid_reg || m_tready) begin
                out_next       = step_pixel;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = step_pixel;
                skid_valid_next = 1'b1;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {{(M_TDATA_BITS - M_TDATA_RAW){1'b0}}, out_reg.pixel_colour,
                       out_reg.screen_y, out_reg.screen_x};

    // The skid register is only ever filled behind a full main register.
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a pixel while the main register is empty");

    // A pixel produced against a stalled, full output must be parked, not lost.
    a_pixel_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("pixel produced under a stall was not parked");

    // An advance while idle leaves the line state alone.
    a_idle_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == MODE_ADVANCE && !state_reg.active)
        |=> ($stable(state_reg.cur_x) && $stable(state_reg.cur_y) && !state_reg.active))
        else $error("advance while idle changed the line state");

    // A pixel marked last always ends the line.
    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && step_pixel.last) |=> !state_reg.active)
        else $error("line still active after its last pixel");

endmodule

`default_nettype wire

// ===== design/mplr_step.sv =====
// One rasterizer step: octant setup on a start, one midpoint step on an advance.
`default_nettype none

module mplr_step (
    input  wire                          mode,
    input  mplr_pkg::line_cmd_t          cmd,
    input  mplr_pkg::line_state_t        state,
    input  wire [mplr_pkg::REG_BITS-1:0] screen_width,
    input  wire [mplr_pkg::REG_BITS-1:0] screen_height,
    output mplr_pkg::line_state_t        state_next,
    output logic                         has_result,
    output mplr_pkg::pixel_t             pixel
);
    import mplr_pkg::*;

    function automatic logic major_is_x(input octant_t o);
        major_is_x = (o == OCT_ONE) || (o == OCT_FOUR) || (o == OCT_FIVE) || (o == OCT_EIGHT);
    endfunction

    function automatic delta_t mag(input delta_t v);
        mag = (v < 0) ? -v : v;
    endfunction

    delta_t    dx, dy, adx, ady;
    delta_t    setup_a, setup_b;
    octant_t   oct;
    logic      oct_valid;
    logic      setup_mx;

    delta_t    run_a, run_b;
    logic      run_mx;
    logic      minor_step;
    coord_t    step_x, step_y;
    decision_t dec_step;
    logic      at_end;

    coord_t    pix_x, pix_y;
    logic signed [SUM_BITS-1:0] ext_x, ext_y, half_w, half_h;

    // Octant selection, tested in the fixed order of the eight octants.
    always_comb begin
        dx  = DELTA_BITS'(cmd.end_x) - DELTA_BITS'(cmd.start_x);
        dy  = DELTA_BITS'(cmd.end_y) - DELTA_BITS'(cmd.start_y);
        adx = mag(dx);
        ady = mag(dy);
        oct_valid = 1'b1;
        if (dx >= dy && dx > 0 && dy >= 0) begin
            oct = OCT_ONE;
        end else if (dy >= dx && dx >= 0 && dy > 0) begin
            oct = OCT_TWO;
        end else if (dy >= adx && dx <= 0 && dy > 0) begin
            oct = OCT_THREE;
        end else if (adx >= dy && dx < 0 && dy >= 0) begin
            oct = OCT_FOUR;
        end else if (adx >= ady && dx < 0 && dy <= 0) begin
            oct = OCT_FIVE;
        end else if (ady >= adx && dx <= 0 && dy < 0) begin
            oct = OCT_SIX;
        end else if (ady >= dx && dx >= 0 && dy < 0) begin
            oct = OCT_SEVEN;
        end else if (dx >= dy && dx > 0 && dy <= 0) begin
            oct = OCT_EIGHT;
        end else begin
            oct       = OCT_ONE;
            oct_valid = 1'b0;
        end
        setup_mx = major_is_x(oct);
        setup_a  = setup_mx ? adx : ady;
        setup_b  = setup_mx ? ady : adx;
    end

    // Midpoint step along the major axis of the stored line.
    always_comb begin
        run_mx     = major_is_x(state.octant);
        run_a      = run_mx ? mag(state.delta_x) : mag(state.delta_y);
        run_b      = run_mx ? mag(state.delta_y) : mag(state.delta_x);
        minor_step = ~state.decision[DEC_BITS-1];
        dec_step   = state.decision + DEC_BITS'(run_b) + DEC_BITS'(run_b);
        if (minor_step) begin
            dec_step = dec_step - DEC_BITS'(run_a) - DEC_BITS'(run_a);
        end
        step_x = state.cur_x;
        step_y = state.cur_y;
        if (run_mx || minor_step) begin
            step_x = state.cur_x + ((state.delta_x < 0) ? '1 : COORD_BITS'(1));
        end
        if (!run_mx || minor_step) begin
            step_y = state.cur_y + ((state.delta_y < 0) ? '1 : COORD_BITS'(1));
        end
        at_end = run_mx ? (step_x == state.stop_x) : (step_y == state.stop_y);
    end

    always_comb begin
        state_next = state;
        has_result = 1'b0;
        pix_x      = cmd.start_x;
        pix_y      = cmd.start_y;
        pixel.pixel_colour = state.line_colour;
        pixel.last         = 1'b0;
        case (mode)
            MODE_START: begin
                if (oct_valid) begin
                    has_result             = 1'b1;
                    state_next.active      = 1'b1;
                    state_next.octant      = oct;
                    state_next.cur_x       = cmd.start_x;
                    state_next.cur_y       = cmd.start_y;
                    state_next.stop_x      = cmd.end_x;
                    state_next.stop_y      = cmd.end_y;
                    state_next.delta_x     = dx;
                    state_next.delta_y     = dy;
                    state_next.line_colour = cmd.colour;
                    state_next.decision    = DEC_BITS'(setup_b) + DEC_BITS'(setup_b)
                                             - DEC_BITS'(setup_a);
                end else begin
                    state_next.active = 1'b0;
                end
                pixel.pixel_colour = cmd.colour;
            end
            MODE_ADVANCE: begin
                if (state.active) begin
                    has_result          = 1'b1;
                    state_next.cur_x    = step_x;
                    state_next.cur_y    = step_y;
                    state_next.decision = dec_step;
                    state_next.active   = ~at_end;
                    pixel.last          = at_end;
                end
                pix_x = step_x;
                pix_y = step_y;
            end
            default: begin
                state_next = state;
            end
        endcase
        // Translation to screen coordinates, wrapping at twelve bits.
        ext_x  = SUM_BITS'(pix_x);
        ext_y  = SUM_BITS'(pix_y);
        half_w = SUM_BITS'({1'b0, screen_width[REG_BITS-1:1]});
        half_h = SUM_BITS'({1'b0, screen_height[REG_BITS-1:1]});
        pixel.screen_x = SCREEN_BITS'(ext_x + half_w);
        pixel.screen_y = SCREEN_BITS'(half_h - ext_y);
    end

endmodule

`default_nettype wire
